// File: src/ccirc_pkg.sv
// shared constants, result codes and width helpers for the circumcircle block
package ccirc_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;

	localparam int STATUS_BITS = 2;
	localparam int CENTER_BITS = 48;
	localparam int RADIUS_BITS = 47;
	localparam int TANGENT_BITS = 17;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [STATUS_BITS-1:0] ST_CIRCLE = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_LINE = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_SAME = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_SAT = 2'd3;

	function automatic int diff_bits(input int c);
		return c + 1;
	endfunction

	function automatic int det_bits(input int c);
		return 2 * (c + 1) + 1;
	endfunction

	// ax, ay, four differences, determinant, degenerate flag, status, tangent
	function automatic int entry_bits(input int c);
		return 2 * c + 4 * diff_bits(c) + det_bits(c) + 1 + STATUS_BITS + 2 * TANGENT_BITS;
	endfunction

endpackage

// File: src/ccirc_front.sv
// front end: takes a word, forms edge vectors and determinant, classifies degenerate cases
module ccirc_front #(
	parameter int COORD_BITS = ccirc_pkg::COORD_BITS_DEF,
	localparam int EB = ccirc_pkg::entry_bits(COORD_BITS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] point_a_x,
	input  logic signed [COORD_BITS-1:0] point_a_y,
	input  logic signed [COORD_BITS-1:0] point_b_x,
	input  logic signed [COORD_BITS-1:0] point_b_y,
	input  logic signed [COORD_BITS-1:0] point_c_x,
	input  logic signed [COORD_BITS-1:0] point_c_y,
	output logic                         push,
	input  logic                         full,
	output logic [EB-1:0]                entry
);

	localparam int C = COORD_BITS;
	localparam int DW = ccirc_pkg::diff_bits(C);
	localparam int DETW = ccirc_pkg::det_bits(C);
	localparam int TB = ccirc_pkg::TANGENT_BITS;
	localparam int XW = (DW > TB) ? DW : TB;

	logic                   vld_s1;
	logic signed [C-1:0]    ax_s1, ay_s1;
	logic signed [DW-1:0]   bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [DETW-1:0] det;
	logic                   deg, bnz, cnz;
	logic [ccirc_pkg::STATUS_BITS-1:0] st;
	logic signed [DW-1:0]   tsx, tsy;
	logic signed [XW-1:0]   tex, tey;
	logic [TB-1:0]          tgx, tgy;

	assign busy = vld_s1 && full;
	assign push = vld_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!busy) begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			ax_s1 <= point_a_x;
			ay_s1 <= point_a_y;
			bx_s1 <= DW'(point_b_x) - DW'(point_a_x);
			by_s1 <= DW'(point_b_y) - DW'(point_a_y);
			cx_s1 <= DW'(point_c_x) - DW'(point_a_x);
			cy_s1 <= DW'(point_c_y) - DW'(point_a_y);
		end
	end

	assign det = DETW'(bx_s1) * DETW'(cy_s1) - DETW'(by_s1) * DETW'(cx_s1);
	assign deg = (det == '0);
	assign bnz = (bx_s1 != '0) || (by_s1 != '0);
	assign cnz = (cx_s1 != '0) || (cy_s1 != '0);

	always_comb begin
		if (bnz) begin
			tsx = -bx_s1;
			tsy = -by_s1;
		end else if (cnz) begin
			tsx = -cx_s1;
			tsy = -cy_s1;
		end else begin
			tsx = DW'(ax_s1);
			tsy = DW'(ay_s1);
		end
		if (!deg) begin
			st = ccirc_pkg::ST_CIRCLE;
		end else if (bnz || cnz) begin
			st = ccirc_pkg::ST_LINE;
		end else begin
			st = ccirc_pkg::ST_SAME;
		end
	end

	assign tex = XW'(tsx);
	assign tey = XW'(tsy);
	assign tgx = deg ? tex[TB-1:0] : '0;
	assign tgy = deg ? tey[TB-1:0] : '0;

	assign entry = {ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1, det, deg, st, tgx, tgy};

endmodule

// File: src/ccirc_queue.sv
// short fifo between front and back end
module ccirc_queue #(
	parameter int W = 8,
	parameter int DEPTH = ccirc_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wr_data,
	input  logic         pop,
	output logic [W-1:0] rd_data,
	output logic         empty,
	output logic         full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign empty = (count_q == '0);
	assign full = (count_q == CW'(DEPTH));
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/ccirc_back.sv
// back end: products, pipelined square root and three pipelined dividers, rounding and clamping
module ccirc_back #(
	parameter int COORD_BITS = ccirc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS = ccirc_pkg::FRAC_BITS_DEF,
	localparam int EB = ccirc_pkg::entry_bits(COORD_BITS)
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	input  logic [EB-1:0]                              entry,
	output logic                                       done,
	output logic [ccirc_pkg::STATUS_BITS-1:0]          status,
	output logic signed [ccirc_pkg::CENTER_BITS-1:0]   center_x,
	output logic signed [ccirc_pkg::CENTER_BITS-1:0]   center_y,
	output logic [ccirc_pkg::RADIUS_BITS-1:0]          radius,
	output logic signed [ccirc_pkg::TANGENT_BITS-1:0]  tangent_x,
	output logic signed [ccirc_pkg::TANGENT_BITS-1:0]  tangent_y
);

	localparam int C = COORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int TB = ccirc_pkg::TANGENT_BITS;
	localparam int SB = ccirc_pkg::STATUS_BITS;
	localparam int CB = ccirc_pkg::CENTER_BITS;
	localparam int RB = ccirc_pkg::RADIUS_BITS;
	localparam int QB = CB;
	localparam int DW = ccirc_pkg::diff_bits(C);
	localparam int DETW = ccirc_pkg::det_bits(C);
	localparam int DDW = DETW + 1;
	localparam int DMW = DDW;
	localparam int DVW = DMW + 1;
	localparam int SQW = 2 * C + 1;
	localparam int SPW = SQW + 1;
	localparam int EW = C + 2;
	localparam int EEW = 2 * C + 3;
	localparam int EEPW = EEW + 1;
	localparam int BCW = 2 * SQW;
	localparam int LPW = SQW + EEW;
	localparam int SW = BCW + EEW;
	localparam int AXW = C + DDW;
	localparam int NXW = DW + SQW + 2;
	localparam int TXW = ((AXW > NXW) ? AXW : NXW) + 1;
	localparam int NW = TXW + F + 1;
	localparam int XW = (NW > QB) ? NW : QB;
	localparam int CMW = (XW > DVW + QB) ? XW : DVW + QB;
	localparam int PW = SW + 2 * F + 2;
	localparam int RW = (PW + 1) / 2;
	localparam int RAD = 2 * RW;
	localparam int RMW = RW + 3;
	localparam int RXW = (RW > QB) ? RW : QB;
	localparam int RCW = ((RXW > DMW + QB) ? RXW : DMW + QB) + 1;

	typedef struct packed {
		logic          deg;
		logic [SB-1:0] st;
		logic [TB-1:0] tgx;
		logic [TB-1:0] tgy;
	} info_t;

	typedef struct packed {
		info_t          info;
		logic [XW-1:0]  numx;
		logic [XW-1:0]  numy;
		logic [DMW-1:0] dmag;
		logic           negx;
		logic           negy;
		logic           ovx;
		logic           ovy;
	} sq_ctx_t;

	typedef struct packed {
		info_t          info;
		logic [DMW-1:0] dmag;
		logic           negx;
		logic           negy;
		logic           ovx;
		logic           ovy;
		logic           ovr;
		logic [DVW-1:0] remx;
		logic [DVW-1:0] remy;
		logic [DMW-1:0] remr;
		logic [QB-1:0]  lowx;
		logic [QB-1:0]  lowy;
		logic [QB-1:0]  lowr;
		logic [QB-1:0]  qx;
		logic [QB-1:0]  qy;
		logic [QB-1:0]  qr;
	} dv_t;

	// unpack queue word
	logic signed [C-1:0]    e_ax, e_ay;
	logic signed [DW-1:0]   e_bx, e_by, e_cx, e_cy;
	logic signed [DETW-1:0] e_det;
	info_t                  e_info;

	assign {e_ax, e_ay, e_bx, e_by, e_cx, e_cy, e_det, e_info} = entry;

	// stage 1: squares, edge vector, doubled determinant
	logic                   v_s1;
	info_t                  info_s1;
	logic signed [C-1:0]    ax_s1, ay_s1;
	logic signed [DW-1:0]   bx_s1, by_s1, cx_s1, cy_s1;
	logic [SQW-1:0]         bb_s1, cc_s1;
	logic [EEW-1:0]         ee_s1;
	logic signed [DDW-1:0]  d_s1;
	logic signed [EW-1:0]   ex, ey;

	assign ex = EW'(e_bx) - EW'(e_cx);
	assign ey = EW'(e_by) - EW'(e_cy);

	always_ff @(posedge clk) begin
		info_s1 <= e_info;
		ax_s1 <= e_ax;
		ay_s1 <= e_ay;
		bx_s1 <= e_bx;
		by_s1 <= e_by;
		cx_s1 <= e_cx;
		cy_s1 <= e_cy;
		bb_s1 <= SQW'(SPW'(e_bx) * SPW'(e_bx) + SPW'(e_by) * SPW'(e_by));
		cc_s1 <= SQW'(SPW'(e_cx) * SPW'(e_cx) + SPW'(e_cy) * SPW'(e_cy));
		ee_s1 <= EEW'(EEPW'(ex) * EEPW'(ex) + EEPW'(ey) * EEPW'(ey));
		d_s1 <= {e_det, 1'b0};
	end

	// stage 2: bisector numerators, a times d, |b|^2 |c|^2
	logic                   v_s2;
	info_t                  info_s2;
	logic signed [NXW-1:0]  nx_s2, ny_s2;
	logic signed [AXW-1:0]  adx_s2, ady_s2;
	logic [BCW-1:0]         bcc_s2;
	logic [EEW-1:0]         ee_s2;
	logic signed [DDW-1:0]  d_s2;
	logic signed [NXW-1:0]  bbs, ccs;

	assign bbs = NXW'($signed({1'b0, bb_s1}));
	assign ccs = NXW'($signed({1'b0, cc_s1}));

	always_ff @(posedge clk) begin
		info_s2 <= info_s1;
		nx_s2 <= NXW'(cy_s1) * bbs - NXW'(by_s1) * ccs;
		ny_s2 <= NXW'(bx_s1) * ccs - NXW'(cx_s1) * bbs;
		adx_s2 <= AXW'(ax_s1) * AXW'(d_s1);
		ady_s2 <= AXW'(ay_s1) * AXW'(d_s1);
		bcc_s2 <= BCW'(bb_s1) * BCW'(cc_s1);
		ee_s2 <= ee_s1;
		d_s2 <= d_s1;
	end

	// stage 3: center numerators, split product for the radius
	logic                   v_s3;
	info_t                  info_s3;
	logic signed [TXW-1:0]  tx_s3, ty_s3;
	logic [LPW-1:0]         slo_s3, shi_s3;
	logic signed [DDW-1:0]  d_s3;

	always_ff @(posedge clk) begin
		info_s3 <= info_s2;
		tx_s3 <= TXW'(adx_s2) + TXW'(nx_s2);
		ty_s3 <= TXW'(ady_s2) + TXW'(ny_s2);
		slo_s3 <= LPW'(bcc_s2[SQW-1:0]) * LPW'(ee_s2);
		shi_s3 <= LPW'(bcc_s2[BCW-1:SQW]) * LPW'(ee_s2);
		d_s3 <= d_s2;
	end

	// stage 4: magnitudes and rounding offsets
	logic                   v_s4;
	info_t                  info_s4;
	logic [SW-1:0]          s_s4;
	logic [XW-1:0]          numx_s4, numy_s4;
	logic [DMW-1:0]         dmag_s4;
	logic                   negx_s4, negy_s4;
	logic [TXW-1:0]         tmx, tmy;
	logic [DMW-1:0]         dm;

	assign tmx = tx_s3[TXW-1] ? -tx_s3 : tx_s3;
	assign tmy = ty_s3[TXW-1] ? -ty_s3 : ty_s3;
	assign dm = d_s3[DDW-1] ? -d_s3 : d_s3;

	always_ff @(posedge clk) begin
		info_s4 <= info_s3;
		s_s4 <= SW'(slo_s3) + (SW'(shi_s3) << SQW);
		numx_s4 <= XW'((NW'(tmx) << (F + 1)) + NW'(dm));
		numy_s4 <= XW'((NW'(tmy) << (F + 1)) + NW'(dm));
		dmag_s4 <= dm;
		negx_s4 <= tx_s3[TXW-1] ^ d_s3[DDW-1];
		negy_s4 <= ty_s3[TXW-1] ^ d_s3[DDW-1];
	end

	// square root, two radicand bits per stage; entry 0 is the load stage
	logic           sq_vld_sk [0:RW];
	logic [RMW-1:0] sq_rem_sk [0:RW];
	logic [RW-1:0]  sq_root_sk [0:RW];
	logic [RAD-1:0] sq_rad_sk [0:RW];
	sq_ctx_t        sq_ctx_sk [0:RW];
	logic [DVW-1:0] dv4;

	assign dv4 = {dmag_s4, 1'b0};

	always_ff @(posedge clk) begin
		sq_rem_sk[0] <= '0;
		sq_root_sk[0] <= '0;
		sq_rad_sk[0] <= RAD'(s_s4) << (2 * F + 2);
		sq_ctx_sk[0].info <= info_s4;
		sq_ctx_sk[0].numx <= numx_s4;
		sq_ctx_sk[0].numy <= numy_s4;
		sq_ctx_sk[0].dmag <= dmag_s4;
		sq_ctx_sk[0].negx <= negx_s4;
		sq_ctx_sk[0].negy <= negy_s4;
		// quotient at or past 2^QB always clamps
		sq_ctx_sk[0].ovx <= CMW'(numx_s4) >= (CMW'(dv4) << QB);
		sq_ctx_sk[0].ovy <= CMW'(numy_s4) >= (CMW'(dv4) << QB);
	end

	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		logic [RMW-1:0] remt, trial;
		logic           take;

		assign remt = {sq_rem_sk[j][RMW-3:0], sq_rad_sk[j][RAD-1 -: 2]};
		assign trial = RMW'({sq_root_sk[j], 2'b01});
		assign take = (remt >= trial);

		always_ff @(posedge clk) begin
			sq_rem_sk[j+1] <= take ? remt - trial : remt;
			sq_root_sk[j+1] <= {sq_root_sk[j][RW-2:0], take};
			sq_rad_sk[j+1] <= sq_rad_sk[j] << 2;
			sq_ctx_sk[j+1] <= sq_ctx_sk[j];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_sk[j+1] <= 1'b0;
			end else begin
				sq_vld_sk[j+1] <= sq_vld_sk[j];
			end
		end
	end

	// divider load: radius range check and first partial remainders
	logic           dv_vld_sk [0:QB];
	dv_t            dv_sk [0:QB];
	logic [RXW-1:0] rext;
	sq_ctx_t        sc;

	assign sc = sq_ctx_sk[RW];
	assign rext = RXW'(sq_root_sk[RW]);

	always_ff @(posedge clk) begin
		dv_sk[0].info <= sc.info;
		dv_sk[0].dmag <= sc.dmag;
		dv_sk[0].negx <= sc.negx;
		dv_sk[0].negy <= sc.negy;
		dv_sk[0].ovx <= sc.ovx;
		dv_sk[0].ovy <= sc.ovy;
		// floor(root/|d|) reaching 2^QB-1 rounds past the radius range
		dv_sk[0].ovr <= RCW'(rext) >= ((RCW'(sc.dmag) << QB) - RCW'(sc.dmag));
		dv_sk[0].remx <= DVW'(sc.numx >> QB);
		dv_sk[0].remy <= DVW'(sc.numy >> QB);
		dv_sk[0].remr <= DMW'(rext >> QB);
		dv_sk[0].lowx <= sc.numx[QB-1:0];
		dv_sk[0].lowy <= sc.numy[QB-1:0];
		dv_sk[0].lowr <= rext[QB-1:0];
		dv_sk[0].qx <= '0;
		dv_sk[0].qy <= '0;
		dv_sk[0].qr <= '0;
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [DVW:0]   rtx, rty, dvs;
		logic [DMW:0]   rtr, dms;
		logic           bx, by, br;

		assign dvs = {1'b0, dv_sk[k].dmag, 1'b0};
		assign dms = {1'b0, dv_sk[k].dmag};
		assign rtx = {dv_sk[k].remx, dv_sk[k].lowx[QB-1]};
		assign rty = {dv_sk[k].remy, dv_sk[k].lowy[QB-1]};
		assign rtr = {dv_sk[k].remr, dv_sk[k].lowr[QB-1]};
		assign bx = (rtx >= dvs);
		assign by = (rty >= dvs);
		assign br = (rtr >= dms);

		always_ff @(posedge clk) begin
			dv_sk[k+1].info <= dv_sk[k].info;
			dv_sk[k+1].dmag <= dv_sk[k].dmag;
			dv_sk[k+1].negx <= dv_sk[k].negx;
			dv_sk[k+1].negy <= dv_sk[k].negy;
			dv_sk[k+1].ovx <= dv_sk[k].ovx;
			dv_sk[k+1].ovy <= dv_sk[k].ovy;
			dv_sk[k+1].ovr <= dv_sk[k].ovr;
			dv_sk[k+1].remx <= DVW'(bx ? rtx - dvs : rtx);
			dv_sk[k+1].remy <= DVW'(by ? rty - dvs : rty);
			dv_sk[k+1].remr <= DMW'(br ? rtr - dms : rtr);
			dv_sk[k+1].lowx <= dv_sk[k].lowx << 1;
			dv_sk[k+1].lowy <= dv_sk[k].lowy << 1;
			dv_sk[k+1].lowr <= dv_sk[k].lowr << 1;
			dv_sk[k+1].qx <= {dv_sk[k].qx[QB-2:0], bx};
			dv_sk[k+1].qy <= {dv_sk[k].qy[QB-2:0], by};
			dv_sk[k+1].qr <= {dv_sk[k].qr[QB-2:0], br};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_sk[k+1] <= 1'b0;
			end else begin
				dv_vld_sk[k+1] <= dv_vld_sk[k];
			end
		end
	end

	// output: sign, clamp, round radius, pick degenerate constants
	localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
	localparam logic [RB-1:0] RMAX = '1;

	dv_t           fo;
	logic [CB-1:0] cx_v, cy_v;
	logic [RB-1:0] r_v;
	logic          satx, saty, satr;
	logic [QB-1:0] rsum;

	logic          done_q;
	logic [SB-1:0] status_q;
	logic [CB-1:0] center_x_q, center_y_q;
	logic [RB-1:0] radius_q;
	logic [TB-1:0] tangent_x_q, tangent_y_q;

	assign fo = dv_sk[QB];
	assign rsum = fo.qr + QB'(1);

	always_comb begin
		satx = fo.ovx;
		if (fo.negx) begin
			if (fo.ovx || fo.qx > CMIN) begin
				satx = 1'b1;
				cx_v = CMIN;
			end else begin
				cx_v = CB'(0) - fo.qx;
			end
		end else begin
			if (fo.ovx || fo.qx > CMAX) begin
				satx = 1'b1;
				cx_v = CMAX;
			end else begin
				cx_v = fo.qx;
			end
		end
		saty = fo.ovy;
		if (fo.negy) begin
			if (fo.ovy || fo.qy > CMIN) begin
				saty = 1'b1;
				cy_v = CMIN;
			end else begin
				cy_v = CB'(0) - fo.qy;
			end
		end else begin
			if (fo.ovy || fo.qy > CMAX) begin
				saty = 1'b1;
				cy_v = CMAX;
			end else begin
				cy_v = fo.qy;
			end
		end
		satr = fo.ovr;
		r_v = fo.ovr ? RMAX : rsum[RB:1];
	end

	always_ff @(posedge clk) begin
		if (fo.info.deg) begin
			status_q <= fo.info.st;
			center_x_q <= CMAX;
			center_y_q <= CMAX;
			radius_q <= RMAX;
			tangent_x_q <= fo.info.tgx;
			tangent_y_q <= fo.info.tgy;
		end else begin
			status_q <= (satx || saty || satr) ? ccirc_pkg::ST_SAT : ccirc_pkg::ST_CIRCLE;
			center_x_q <= cx_v;
			center_y_q <= cy_v;
			radius_q <= r_v;
			tangent_x_q <= '0;
			tangent_y_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			sq_vld_sk[0] <= 1'b0;
			dv_vld_sk[0] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			sq_vld_sk[0] <= v_s4;
			dv_vld_sk[0] <= sq_vld_sk[RW];
			done_q <= dv_vld_sk[QB];
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign center_x = center_x_q;
	assign center_y = center_y_q;
	assign radius = radius_q;
	assign tangent_x = tangent_x_q;
	assign tangent_y = tangent_y_q;

endmodule

// File: src/circumcircle_three_points.sv
// throughput: one word per cycle; the root and the dividers each retire one bit per stage
// the back end never stalls, so busy stays low in steady streaming
// done pulses for one cycle per word, in order; the receiver cannot hold it off
// arst_n clears all valid bits and the queue; payload registers are not reset
module circumcircle_three_points #(
	parameter int COORD_BITS = ccirc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS = ccirc_pkg::FRAC_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	output logic                                       busy,
	input  logic signed [COORD_BITS-1:0]               point_a_x,
	input  logic signed [COORD_BITS-1:0]               point_a_y,
	input  logic signed [COORD_BITS-1:0]               point_b_x,
	input  logic signed [COORD_BITS-1:0]               point_b_y,
	input  logic signed [COORD_BITS-1:0]               point_c_x,
	input  logic signed [COORD_BITS-1:0]               point_c_y,
	output logic                                       done,
	output logic [ccirc_pkg::STATUS_BITS-1:0]          status,
	output logic signed [ccirc_pkg::CENTER_BITS-1:0]   center_x,
	output logic signed [ccirc_pkg::CENTER_BITS-1:0]   center_y,
	output logic [ccirc_pkg::RADIUS_BITS-1:0]          radius,
	output logic signed [ccirc_pkg::TANGENT_BITS-1:0]  tangent_x,
	output logic signed [ccirc_pkg::TANGENT_BITS-1:0]  tangent_y
);

	localparam int EB = ccirc_pkg::entry_bits(COORD_BITS);

	logic          push, full, empty;
	logic [EB-1:0] front_entry, back_entry;

	ccirc_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.point_a_x(point_a_x),
		.point_a_y(point_a_y),
		.point_b_x(point_b_x),
		.point_b_y(point_b_y),
		.point_c_x(point_c_x),
		.point_c_y(point_c_y),
		.push(push),
		.full(full),
		.entry(front_entry)
	);

	ccirc_queue #(
		.W(EB),
		.DEPTH(ccirc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data(front_entry),
		.pop(!empty),
		.rd_data(back_entry),
		.empty(empty),
		.full(full)
	);

	ccirc_back #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(!empty),
		.entry(back_entry),
		.done(done),
		.status(status),
		.center_x(center_x),
		.center_y(center_y),
		.radius(radius),
		.tangent_x(tangent_x),
		.tangent_y(tangent_y)
	);

endmodule
